FILE: src/tws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Three-wire serial master package
// Transfer types, field layouts, constants and BCD helpers shared by the core.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int unsigned ByteBits   = 8;
    localparam int unsigned FrameBits  = 2 * ByteBits;
    localparam int unsigned CountBits  = $clog2(FrameBits + 1);
    localparam int unsigned ApbData    = 32;
    localparam int unsigned ApbAddr    = 3;

    // Request codes carried in req_type.
    localparam logic [1:0] ReqTick  = 2'd0;
    localparam logic [1:0] ReqWrite = 2'd1;
    localparam logic [1:0] ReqRead  = 2'd2;

    // Register index taken from the word address.
    localparam logic RegHalfPeriod = 1'b0;

    localparam logic [ByteBits-1:0] HalfPeriodReset = 8'd1;
    localparam logic [ByteBits-1:0] ReadForceMask   = 8'h01;
    localparam logic [ByteBits-1:0] TopBitSet       = 8'h80;
    localparam logic [ByteBits-1:0] TopBitClear     = 8'h7F;

    // Reciprocal of ten for 8-bit values: q = (v * 205) >> 11.
    localparam logic [ByteBits-1:0] RecipTen   = 8'd205;
    localparam int unsigned         RecipShift = 11;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [ByteBits-1:0] command;
        logic [ByteBits-1:0] write_value;
        logic                bcd_convert;
        logic                clear_top_bit;
        logic                sda_in;
    } t_tws_in;

    typedef struct packed {
        logic                sclk;
        logic                sda_out;
        logic                sda_drive;
        logic                chip_enable;
        logic                busy_res;
        logic                done_res;
        logic [ByteBits-1:0] read_value;
        logic                rejected;
    } t_tws_out;

    // Binary to BCD, truncated to one byte.
    function automatic logic [ByteBits-1:0] to_bcd(input logic [ByteBits-1:0] v);
        logic [2*ByteBits-1:0] prod;
        logic [4:0]            q;
        logic [ByteBits-1:0]   q10;
        logic [ByteBits-1:0]   r;
        prod = {8'd0, v} * {8'd0, RecipTen};
        q    = prod[RecipShift+4:RecipShift];
        q10  = {q[4:0], 3'b000} + {2'b00, q[4:0], 1'b0};
        r    = v - q10;
        return {q[3:0], r[3:0]};
    endfunction

    // BCD to binary: low nibble plus ten times the high nibble.
    function automatic logic [ByteBits-1:0] from_bcd(input logic [ByteBits-1:0] v);
        return {4'd0, v[3:0]} + {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0};
    endfunction

endpackage
`default_nettype wire

FILE: src/tws_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style slave holding the clock half period in ticks.
// ----------------------------------------------------------------------------
module tws_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tws_pkg::ApbAddr-1:0]     paddr,
    input  wire logic [tws_pkg::ApbData-1:0]     pwdata,
    output logic      [tws_pkg::ApbData-1:0]     prdata,
    output logic                                 pready,
    output logic      [tws_pkg::ByteBits-1:0]    o_half_period
);

    logic [tws_pkg::ByteBits-1:0] r_half_period;
    logic                         hit;

    assign hit   = (paddr[tws_pkg::ApbAddr-1] == tws_pkg::RegHalfPeriod);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= tws_pkg::HalfPeriodReset;
        end else if (psel && penable && pwrite && hit) begin
            r_half_period <= pwdata[tws_pkg::ByteBits-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata[tws_pkg::ByteBits-1:0] = r_half_period;
        end
    end

    assign o_half_period = r_half_period;

endmodule
`default_nettype wire

FILE: src/tws_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Transfer engine
// Input register, tick-driven shift and clock state, one result per item.
// ----------------------------------------------------------------------------
module tws_engine (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [tws_pkg::ByteBits-1:0] i_half_period,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire tws_pkg::t_tws_in             i_item,
    input  wire logic                         i_space,
    output logic                              o_res_valid,
    output tws_pkg::t_tws_out                 o_res
);

    localparam int unsigned W  = tws_pkg::ByteBits;
    localparam int unsigned CW = tws_pkg::CountBits;

    logic               r_s1_valid;
    tws_pkg::t_tws_in   r_s1_item;
    logic               advance;

    logic               r_active,      n_active;
    logic               r_reading,     n_reading;
    logic [2*W-1:0]     r_out_shift,   n_out_shift;
    logic [CW-1:0]      r_bit_count,   n_bit_count;
    logic               r_clock_phase, n_clock_phase;
    logic [W-1:0]       r_phase_ticks, n_phase_ticks;
    logic [W-1:0]       r_in_shift,    n_in_shift;
    logic               r_convert,     n_convert;
    logic               r_mask,        n_mask;

    logic               start_req;
    logic [W-1:0]       wdata;
    logic [W-1:0]       masked;
    logic               done;
    logic               rej;
    logic [W-1:0]       rval;

    assign advance = r_s1_valid && i_space;
    assign o_ready = !r_s1_valid || i_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_item <= i_item;
        end
    end

    assign start_req = (r_s1_item.req_type == tws_pkg::ReqWrite)
                    || (r_s1_item.req_type == tws_pkg::ReqRead);
    assign wdata  = r_s1_item.bcd_convert ? tws_pkg::to_bcd(r_s1_item.write_value)
                                          : r_s1_item.write_value;
    assign masked = r_mask ? (r_in_shift & tws_pkg::TopBitClear) : r_in_shift;

    always_comb begin
        n_active      = r_active;
        n_reading     = r_reading;
        n_out_shift   = r_out_shift;
        n_bit_count   = r_bit_count;
        n_clock_phase = r_clock_phase;
        n_phase_ticks = r_phase_ticks;
        n_in_shift    = r_in_shift;
        n_convert     = r_convert;
        n_mask        = r_mask;
        done          = 1'b0;
        rej           = 1'b0;
        rval          = '0;
        if (!r_active && start_req) begin
            n_reading     = (r_s1_item.req_type == tws_pkg::ReqRead);
            n_convert     = r_s1_item.bcd_convert;
            n_mask        = r_s1_item.clear_top_bit;
            if (n_reading) begin
                n_out_shift = {{W{1'b0}}, r_s1_item.command | tws_pkg::ReadForceMask};
            end else begin
                n_out_shift = {wdata, r_s1_item.command};
            end
            n_active      = 1'b1;
            n_bit_count   = '0;
            n_clock_phase = 1'b0;
            n_phase_ticks = i_half_period;
            n_in_shift    = '0;
        end else if (r_active) begin
            rej = start_req;
            if (r_phase_ticks < i_half_period) begin
                n_phase_ticks = r_phase_ticks + W'(1);
            end else if (!r_clock_phase) begin
                if (r_bit_count >= CW'(tws_pkg::FrameBits)) begin
                    n_active = 1'b0;
                    done     = 1'b1;
                    if (r_reading) begin
                        rval = r_convert ? tws_pkg::from_bcd(masked) : masked;
                    end
                end else begin
                    // Read data is sampled on the tick that raises the clock.
                    if (r_reading && r_bit_count >= CW'(W)) begin
                        n_in_shift = {r_s1_item.sda_in, r_in_shift[W-1:1]};
                    end
                    n_clock_phase = 1'b1;
                    n_phase_ticks = W'(1);
                end
            end else begin
                n_clock_phase = 1'b0;
                n_phase_ticks = W'(1);
                n_bit_count   = r_bit_count + CW'(1);
                n_out_shift   = {1'b0, r_out_shift[2*W-1:1]};
            end
        end
    end

    always_comb begin
        o_res             = '0;
        o_res.sda_drive   = 1'b1;
        if (n_active) begin
            o_res.sclk = n_clock_phase;
            if (n_reading && n_bit_count >= CW'(W)) begin
                o_res.sda_drive = 1'b0;
            end else begin
                o_res.sda_out = n_out_shift[0];
            end
        end
        o_res.chip_enable = n_active;
        o_res.busy_res    = n_active;
        o_res.done_res    = done;
        o_res.read_value  = rval;
        o_res.rejected    = rej;
    end

    assign o_res_valid = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_reading     <= 1'b0;
            r_out_shift   <= '0;
            r_bit_count   <= '0;
            r_clock_phase <= 1'b0;
            r_phase_ticks <= '0;
            r_in_shift    <= '0;
            r_convert     <= 1'b0;
            r_mask        <= 1'b0;
        end else if (advance) begin
            r_active      <= n_active;
            r_reading     <= n_reading;
            r_out_shift   <= n_out_shift;
            r_bit_count   <= n_bit_count;
            r_clock_phase <= n_clock_phase;
            r_phase_ticks <= n_phase_ticks;
            r_in_shift    <= n_in_shift;
            r_convert     <= n_convert;
            r_mask        <= n_mask;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= CW'(tws_pkg::FrameBits))
        else $error("bit counter past end of frame");

    a_high_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_clock_phase) |-> (r_bit_count < CW'(tws_pkg::FrameBits)))
        else $error("clock high after the last bit");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_active && start_req) |=> (r_active && r_bit_count == '0))
        else $error("start request did not open a transfer");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && done) |=> !r_active)
        else $error("transfer still active after done");

endmodule
`default_nettype wire

FILE: src/tws_obuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry queue that registers results and absorbs output stalls.
// ----------------------------------------------------------------------------
module tws_obuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire tws_pkg::t_tws_out i_data,
    output logic                   o_space,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output tws_pkg::t_tws_out      o_data
);

    tws_pkg::t_tws_out r_slot [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              pop;

    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/three_wire_serial_master_core.sv
`default_nettype none
// Each result passes the input register and then the result queue before it is offered.
// Throughput: one item per cycle while the queue has room; the input register and
// the two-entry result queue keep the input open while a result waits to be taken.
// Reset (synchronous, active low) idles the bus, clears all transfer state
// and sets the half period to one tick.
// ----------------------------------------------------------------------------
// Three-wire serial master core
// Tick-driven LSB-first command and data transfers with optional BCD handling.
// ----------------------------------------------------------------------------
module three_wire_serial_master_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire tws_pkg::t_tws_in             i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output tws_pkg::t_tws_out                 o_out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tws_pkg::ApbAddr-1:0]  paddr,
    input  wire logic [tws_pkg::ApbData-1:0]  pwdata,
    output logic      [tws_pkg::ApbData-1:0]  prdata,
    output logic                              pready
);

    logic [tws_pkg::ByteBits-1:0] half_period;
    logic                         space;
    logic                         res_valid;
    tws_pkg::t_tws_out            res;

    tws_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_half_period (half_period)
    );

    tws_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_half_period (half_period),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_item        (i_in_data),
        .i_space       (space),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    tws_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire
